[rtl/bsc_pkg.sv]
// shared widths, register codes and types for the barometric compensation core
package bsc_pkg;

    localparam int RAW_W   = 20;
    localparam int TRIM_W  = 48;
    localparam int TEMP_W  = 27;
    localparam int PRESS_W = 32;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TRIM    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TRIM_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TRIM_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TRIM_C = 3'd3;

    // divider geometry: |den| < 2^42, dividend |u|*12500 < 2^77, quotient saturates at 2^39-1
    localparam int DEN_W = 42;
    localparam int QUO_W = 39;
    localparam int XLO_W = 39;
    localparam int X_W   = 77;

    localparam logic [13:0]      PSCALE  = 14'd12500;
    localparam logic [QUO_W-1:0] P_CLAMP = '1;

    localparam int FRONT_STAGES = 10;
    localparam int BACK_STAGES  = 6;
    localparam int LATENCY      = FRONT_STAGES + QUO_W + BACK_STAGES;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_trim;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic              inval;
        logic              neg;
        logic              ovf;
    } t_side;

endpackage

[rtl/bsc_front.sv]
// temperature formula, pressure numerator and denominator, divider set-up
module bsc_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic [bsc_pkg::RAW_W-1:0] i_raw_temp,
    input  logic [bsc_pkg::RAW_W-1:0] i_raw_press,
    input  bsc_pkg::t_trim            i_trim,
    output logic                      o_vld,
    output logic [bsc_pkg::DEN_W-1:0] o_rem,
    output logic [bsc_pkg::DEN_W-1:0] o_ud,
    output logic [bsc_pkg::XLO_W-1:0] o_xlo,
    output bsc_pkg::t_side            o_side
);
    import bsc_pkg::*;

    logic [FRONT_STAGES-1:0] r_vld;

    // stage a
    logic signed [18:0] n_x1;
    logic signed [17:0] n_d4;
    logic signed [34:0] n_a_prod;
    logic signed [35:0] n_a_sq;
    logic signed [34:0] r_a_prod;
    logic [32:0]        r_a_sq;
    logic [RAW_W-1:0]   r_a_rp;

    // stage b
    logic signed [37:0] n_b_v2a;
    logic signed [23:0] r_b_v1;
    logic signed [37:0] r_b_v2a;
    logic [RAW_W-1:0]   r_b_rp;

    // stage c
    logic signed [23:0] w_c_v2;
    logic signed [24:0] n_c_tf;
    logic signed [24:0] r_c_tf;
    logic [RAW_W-1:0]   r_c_rp;

    // stage d
    logic signed [28:0] w_d_t5;
    logic signed [24:0] w_d_a;
    logic signed [49:0] n_d_aa;
    logic signed [40:0] n_d_ap5;
    logic signed [40:0] n_d_ap2;
    logic [TEMP_W-1:0]  r_d_temp;
    logic signed [47:0] r_d_aa;
    logic signed [40:0] r_d_ap5;
    logic signed [40:0] r_d_ap2;
    logic [RAW_W-1:0]   r_d_rp;

    // stage e
    logic signed [63:0] n_e_n1;
    logic signed [63:0] n_e_m1;
    logic signed [63:0] r_e_n1;
    logic signed [63:0] r_e_m1;
    logic signed [40:0] r_e_ap5;
    logic signed [40:0] r_e_ap2;
    logic [TEMP_W-1:0]  r_e_temp;
    logic [RAW_W-1:0]   r_e_rp;

    // stage f
    logic signed [63:0] n_f_n;
    logic signed [63:0] n_f_m;
    logic signed [63:0] r_f_n;
    logic signed [63:0] r_f_m;
    logic [TEMP_W-1:0]  r_f_temp;
    logic [RAW_W-1:0]   r_f_rp;

    // stage g
    logic [20:0]        w_g_rpc;
    logic signed [63:0] n_g_u;
    logic signed [57:0] n_g_dm;
    logic signed [63:0] r_g_u;
    logic signed [57:0] r_g_dm;
    logic [TEMP_W-1:0]  r_g_temp;

    // stage h
    logic signed [42:0] n_h_d;
    logic signed [63:0] w_h_negu;
    logic signed [42:0] r_h_d;
    logic [62:0]        r_h_uu;
    logic               r_h_negu;
    logic [TEMP_W-1:0]  r_h_temp;

    // stage i
    logic signed [42:0] w_i_negd;
    logic [X_W-1:0]     n_i_x;
    logic [X_W-1:0]     r_i_x;
    logic [DEN_W-1:0]   r_i_ud;
    logic               r_i_inval;
    logic               r_i_neg;
    logic [TEMP_W-1:0]  r_i_temp;

    // stage j
    logic [DEN_W-1:0]   w_j_top;
    logic [DEN_W-1:0]   r_j_rem;
    logic [DEN_W-1:0]   r_j_ud;
    logic [XLO_W-1:0]   r_j_xlo;
    t_side              r_j_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[FRONT_STAGES-2:0], i_vld};
        end
    end

    always_comb begin
        n_x1     = $signed({2'b00, i_raw_temp[19:3]}) - $signed({2'b00, i_trim.t1, 1'b0});
        n_d4     = $signed({2'b00, i_raw_temp[19:4]}) - $signed({2'b00, i_trim.t1});
        n_a_prod = n_x1 * $signed(i_trim.t2);
        n_a_sq   = n_d4 * n_d4;

        n_b_v2a  = $signed({1'b0, r_a_sq[32:12]}) * $signed(i_trim.t3);

        w_c_v2   = r_b_v2a[37:14];
        n_c_tf   = 25'(r_b_v1) + 25'(w_c_v2);

        w_d_t5   = 29'(r_c_tf) * 29'sd5 + 29'sd128;
        w_d_a    = r_c_tf - 25'sd128000;
        n_d_aa   = w_d_a * w_d_a;
        n_d_ap5  = w_d_a * $signed(i_trim.p5);
        n_d_ap2  = w_d_a * $signed(i_trim.p2);

        n_e_n1   = r_d_aa * $signed(i_trim.p6);
        n_e_m1   = r_d_aa * $signed(i_trim.p3);

        n_f_n    = r_e_n1 + (64'(r_e_ap5) <<< 17) + (64'($signed(i_trim.p4)) <<< 35);
        n_f_m    = r_e_m1 + (64'(r_e_ap2) <<< 20);

        w_g_rpc  = 21'h100000 - {1'b0, r_f_rp};
        n_g_u    = $signed({12'd0, w_g_rpc, 31'd0}) - r_f_n;
        n_g_dm   = $signed({1'b0, i_trim.p1}) * $signed(r_f_m[63:23]);

        n_h_d    = $signed({11'd0, i_trim.p1, 16'd0}) + 43'($signed(r_g_dm[57:16]));
        w_h_negu = -r_g_u;

        w_i_negd = -r_h_d;
        n_i_x    = X_W'(r_h_uu) * X_W'(PSCALE);

        w_j_top  = DEN_W'(r_i_x[X_W-1:XLO_W]);
    end

    always_ff @(posedge i_clk) begin
        r_a_prod <= n_a_prod;
        r_a_sq   <= n_a_sq[32:0];
        r_a_rp   <= i_raw_press;

        r_b_v1   <= r_a_prod[34:11];
        r_b_v2a  <= n_b_v2a;
        r_b_rp   <= r_a_rp;

        r_c_tf   <= n_c_tf;
        r_c_rp   <= r_b_rp;

        r_d_temp <= TEMP_W'($signed(w_d_t5[28:8]));
        r_d_aa   <= n_d_aa[47:0];
        r_d_ap5  <= n_d_ap5;
        r_d_ap2  <= n_d_ap2;
        r_d_rp   <= r_c_rp;

        r_e_n1   <= n_e_n1;
        r_e_m1   <= n_e_m1;
        r_e_ap5  <= r_d_ap5;
        r_e_ap2  <= r_d_ap2;
        r_e_temp <= r_d_temp;
        r_e_rp   <= r_d_rp;

        r_f_n    <= n_f_n;
        r_f_m    <= n_f_m;
        r_f_temp <= r_e_temp;
        r_f_rp   <= r_e_rp;

        r_g_u    <= n_g_u;
        r_g_dm   <= n_g_dm;
        r_g_temp <= r_f_temp;

        r_h_d    <= n_h_d;
        r_h_uu   <= r_g_u[63] ? w_h_negu[62:0] : r_g_u[62:0];
        r_h_negu <= r_g_u[63];
        r_h_temp <= r_g_temp;

        r_i_x     <= n_i_x;
        r_i_ud    <= r_h_d[42] ? w_i_negd[DEN_W-1:0] : r_h_d[DEN_W-1:0];
        r_i_inval <= (r_h_d == '0);
        r_i_neg   <= r_h_negu ^ r_h_d[42];
        r_i_temp  <= r_h_temp;

        // quotient of 2^39 or more saturates, so the divider only needs 39 bits
        r_j_rem        <= w_j_top;
        r_j_ud         <= r_i_ud;
        r_j_xlo        <= r_i_x[XLO_W-1:0];
        r_j_side.temp  <= r_i_temp;
        r_j_side.inval <= r_i_inval;
        r_j_side.neg   <= r_i_neg;
        r_j_side.ovf   <= (w_j_top >= r_i_ud);
    end

    assign o_vld  = r_vld[FRONT_STAGES-1];
    assign o_rem  = r_j_rem;
    assign o_ud   = r_j_ud;
    assign o_xlo  = r_j_xlo;
    assign o_side = r_j_side;

endmodule

[rtl/bsc_div.sv]
// pipelined restoring divider, one quotient bit per stage
module bsc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic [bsc_pkg::DEN_W-1:0] i_rem,
    input  logic [bsc_pkg::DEN_W-1:0] i_ud,
    input  logic [bsc_pkg::XLO_W-1:0] i_xlo,
    input  bsc_pkg::t_side            i_side,
    output logic                      o_vld,
    output logic [bsc_pkg::QUO_W-1:0] o_quo,
    output bsc_pkg::t_side            o_side
);
    import bsc_pkg::*;

    logic             r_vld  [QUO_W];
    logic [QUO_W-1:0] r_quo  [QUO_W];
    t_side            r_side [QUO_W];
    logic [DEN_W-1:0] r_rem  [QUO_W-1];
    logic [DEN_W-1:0] r_ud   [QUO_W-1];
    logic [XLO_W-1:0] r_xlo  [QUO_W-1];

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        logic             w_vld_in;
        logic [DEN_W-1:0] w_rem_in;
        logic [DEN_W-1:0] w_ud_in;
        logic [XLO_W-1:0] w_xlo_in;
        logic [QUO_W-1:0] w_quo_in;
        t_side            w_side_in;
        logic [DEN_W:0]   w_trial;
        logic [DEN_W:0]   w_diff;
        logic             w_ge;

        if (g == 0) begin : g_first
            assign w_vld_in  = i_vld;
            assign w_rem_in  = i_rem;
            assign w_ud_in   = i_ud;
            assign w_xlo_in  = i_xlo;
            assign w_quo_in  = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_vld_in  = r_vld[g-1];
            assign w_rem_in  = r_rem[g-1];
            assign w_ud_in   = r_ud[g-1];
            assign w_xlo_in  = r_xlo[g-1];
            assign w_quo_in  = r_quo[g-1];
            assign w_side_in = r_side[g-1];
        end

        assign w_trial = {w_rem_in, w_xlo_in[XLO_W-1]};
        assign w_diff  = w_trial - {1'b0, w_ud_in};
        assign w_ge    = (w_trial >= {1'b0, w_ud_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_quo[g]  <= {w_quo_in[QUO_W-2:0], w_ge};
            r_side[g] <= w_side_in;
        end

        if (g < QUO_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[g] <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_ud[g]  <= w_ud_in;
                r_xlo[g] <= {w_xlo_in[XLO_W-2:0], 1'b0};
            end
        end
    end

    assign o_vld  = r_vld[QUO_W-1];
    assign o_quo  = r_quo[QUO_W-1];
    assign o_side = r_side[QUO_W-1];

endmodule

[rtl/bsc_back.sv]
// signed quotient, second-order pressure correction, rounding and output register
module bsc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [bsc_pkg::QUO_W-1:0]   i_quo,
    input  bsc_pkg::t_side              i_side,
    input  bsc_pkg::t_trim              i_trim,
    output logic                        o_vld,
    output logic [bsc_pkg::TEMP_W-1:0]  o_temp_centi,
    output logic [bsc_pkg::PRESS_W-1:0] o_press_pa,
    output logic                        o_press_invalid
);
    import bsc_pkg::*;

    logic [BACK_STAGES-1:0] r_vld;

    // p0: signed quotient, Q16
    logic [QUO_W:0]     w_mag;
    logic signed [39:0] n_0_p;
    logic signed [39:0] r_0_p;
    logic [TEMP_W-1:0]  r_0_temp;
    logic               r_0_inval;

    // p1
    logic signed [31:0] w_1_s;
    logic signed [63:0] n_1_s2;
    logic signed [55:0] n_1_pp8;
    logic [62:0]        r_1_s2;
    logic signed [55:0] r_1_pp8;
    logic signed [39:0] r_1_p;
    logic [TEMP_W-1:0]  r_1_temp;
    logic               r_1_inval;

    // p2
    logic signed [64:0] n_2_t9;
    logic signed [63:0] r_2_t9;
    logic signed [55:0] r_2_pp8;
    logic signed [39:0] r_2_p;
    logic [TEMP_W-1:0]  r_2_temp;
    logic               r_2_inval;

    // p3
    logic signed [49:0] n_3_c;
    logic signed [49:0] r_3_c;
    logic signed [39:0] r_3_p;
    logic [TEMP_W-1:0]  r_3_temp;
    logic               r_3_inval;

    // p4
    logic signed [47:0] n_4_pf;
    logic signed [47:0] r_4_pf;
    logic [TEMP_W-1:0]  r_4_temp;
    logic               r_4_inval;

    // p5
    logic [47:0]        w_5_rnd;
    logic               w_5_pos;
    logic [TEMP_W-1:0]  r_5_temp;
    logic [PRESS_W-1:0] r_5_press;
    logic               r_5_inval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[BACK_STAGES-2:0], i_vld};
        end
    end

    always_comb begin
        w_mag   = i_side.ovf ? {1'b0, P_CLAMP} : {1'b0, i_quo};
        n_0_p   = i_side.neg ? -$signed(w_mag) : $signed(w_mag);

        w_1_s   = r_0_p[39:8];
        n_1_s2  = w_1_s * w_1_s;
        n_1_pp8 = r_0_p * $signed(i_trim.p8);

        n_2_t9  = $signed({1'b0, r_1_s2[62:15]}) * $signed(i_trim.p9);

        n_3_c   = 50'($signed(r_2_t9[63:16])) + 50'($signed(r_2_pp8[55:15]))
                + 50'($signed({i_trim.p7, 16'd0}));

        n_4_pf  = 48'(r_3_p) + 48'($signed(r_3_c[49:4]));

        // round half up, Q16 to whole pascal; positive range never exceeds 32 bits
        w_5_pos = !r_4_pf[47] && (r_4_pf != '0);
        w_5_rnd = r_4_pf + 48'd32768;
    end

    always_ff @(posedge i_clk) begin
        r_0_p     <= n_0_p;
        r_0_temp  <= i_side.temp;
        r_0_inval <= i_side.inval;

        r_1_s2    <= n_1_s2[62:0];
        r_1_pp8   <= n_1_pp8;
        r_1_p     <= r_0_p;
        r_1_temp  <= r_0_temp;
        r_1_inval <= r_0_inval;

        r_2_t9    <= n_2_t9[63:0];
        r_2_pp8   <= r_1_pp8;
        r_2_p     <= r_1_p;
        r_2_temp  <= r_1_temp;
        r_2_inval <= r_1_inval;

        r_3_c     <= n_3_c;
        r_3_p     <= r_2_p;
        r_3_temp  <= r_2_temp;
        r_3_inval <= r_2_inval;

        r_4_pf    <= n_4_pf;
        r_4_temp  <= r_3_temp;
        r_4_inval <= r_3_inval;

        r_5_temp  <= r_4_temp;
        r_5_inval <= r_4_inval;
        r_5_press <= (w_5_pos && !r_4_inval) ? w_5_rnd[47:16] : '0;
    end

    assign o_vld           = r_vld[BACK_STAGES-1];
    assign o_temp_centi    = r_5_temp;
    assign o_press_pa      = r_5_press;
    assign o_press_invalid = r_5_inval;

endmodule

[rtl/baro_sensor_compensation_core.sv]
// top level: trim registers, item entry and the three pipeline sections
//
//  channel   direction  handshake                 payload
//  item      in         start, busy               i_raw_temp, i_raw_press
//  result    out        o_res_strobe (one cycle)  o_temp_centi, o_press_pa, o_press_invalid
//  trim      in         i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
//
//  one item per clock outside reset; each item passes in order through the pipeline stages
//  (10 arithmetic stages, 39 divider stages of one quotient bit each, 6 correction stages)
//  busy and o_cfg_ready only reflect reset; outside reset an item is taken in every cycle that start is high
//  synchronous active-low reset clears trims and all stage valid bits
//  results cannot be held off, so the pipeline never stalls
module baro_sensor_compensation_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bsc_pkg::RAW_W-1:0]     i_raw_temp,
    input  logic [bsc_pkg::RAW_W-1:0]     i_raw_press,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bsc_pkg::TRIM_W-1:0]    i_cfg_data,
    output logic                          o_res_strobe,
    output logic [bsc_pkg::TEMP_W-1:0]    o_temp_centi,
    output logic [bsc_pkg::PRESS_W-1:0]   o_press_pa,
    output logic                          o_press_invalid
);
    import bsc_pkg::*;

    logic [TRIM_W-1:0] r_temp_trim;
    logic [TRIM_W-1:0] r_press_trim_a;
    logic [TRIM_W-1:0] r_press_trim_b;
    logic [TRIM_W-1:0] r_press_trim_c;
    t_trim             w_trim;
    logic              w_accept;

    logic              w_f_vld;
    logic [DEN_W-1:0]  w_f_rem;
    logic [DEN_W-1:0]  w_f_ud;
    logic [XLO_W-1:0]  w_f_xlo;
    t_side             w_f_side;
    logic              w_d_vld;
    logic [QUO_W-1:0]  w_d_quo;
    t_side             w_d_side;

    assign busy        = !i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign w_accept    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_trim    <= '0;
            r_press_trim_a <= '0;
            r_press_trim_b <= '0;
            r_press_trim_c <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TEMP_TRIM:    r_temp_trim    <= i_cfg_data;
                CFG_PRESS_TRIM_A: r_press_trim_a <= i_cfg_data;
                CFG_PRESS_TRIM_B: r_press_trim_b <= i_cfg_data;
                CFG_PRESS_TRIM_C: r_press_trim_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_trim.t1 = r_temp_trim[15:0];
    assign w_trim.t2 = r_temp_trim[31:16];
    assign w_trim.t3 = r_temp_trim[47:32];
    assign w_trim.p1 = r_press_trim_a[15:0];
    assign w_trim.p2 = r_press_trim_a[31:16];
    assign w_trim.p3 = r_press_trim_a[47:32];
    assign w_trim.p4 = r_press_trim_b[15:0];
    assign w_trim.p5 = r_press_trim_b[31:16];
    assign w_trim.p6 = r_press_trim_b[47:32];
    assign w_trim.p7 = r_press_trim_c[15:0];
    assign w_trim.p8 = r_press_trim_c[31:16];
    assign w_trim.p9 = r_press_trim_c[47:32];

    bsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (w_accept),
        .i_raw_temp  (i_raw_temp),
        .i_raw_press (i_raw_press),
        .i_trim      (w_trim),
        .o_vld       (w_f_vld),
        .o_rem       (w_f_rem),
        .o_ud        (w_f_ud),
        .o_xlo       (w_f_xlo),
        .o_side      (w_f_side)
    );

    bsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_f_vld),
        .i_rem   (w_f_rem),
        .i_ud    (w_f_ud),
        .i_xlo   (w_f_xlo),
        .i_side  (w_f_side),
        .o_vld   (w_d_vld),
        .o_quo   (w_d_quo),
        .o_side  (w_d_side)
    );

    bsc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vld           (w_d_vld),
        .i_quo           (w_d_quo),
        .i_side          (w_d_side),
        .i_trim          (w_trim),
        .o_vld           (o_res_strobe),
        .o_temp_centi    (o_temp_centi),
        .o_press_pa      (o_press_pa),
        .o_press_invalid (o_press_invalid)
    );

endmodule

[rtl/bsc_checker.sv]
// port-level checks on the compensation core, bound to the top level
module bsc_port_checks (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_res_strobe,
    input logic [bsc_pkg::PRESS_W-1:0] o_press_pa,
    input logic                        o_press_invalid
);
    import bsc_pkg::*;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_res_strobe)
        else $error("item taken but no result after the pipeline latency");

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching item");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_press_invalid) |-> (o_press_pa == '0))
        else $error("invalid pressure result is not zero");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_strobe)
        else $error("result strobe right after reset");

endmodule

bind baro_sensor_compensation_core bsc_port_checks u_bsc_port_checks (.*);
